FILE: design/bmpd_pkg.sv
`default_nettype none
package bmpd_pkg;

   localparam logic [31:0] HEADER_END = 32'd33;

   localparam logic [1:0] CMD_PAL_WR  = 2'd0;
   localparam logic [1:0] CMD_ERROR   = 2'd1;
   localparam logic [1:0] CMD_PIX_RGB = 2'd2;
   localparam logic [1:0] CMD_PIX_IDX = 2'd3;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [4:0]  depth;
      logic [2:0]  last_step;
      logic [10:0] x;
      logic [10:0] y;
      logic [15:0] color;
      logic [7:0]  pal_addr;
   } cmd_type;

endpackage
`default_nettype wire

FILE: design/bmpd_channels.sv
`default_nettype none
interface bmpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;

   modport source (output valid, output data_byte, output start_of_file, input ready);
   modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface bmpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] pixel_x;
   logic [10:0] pixel_y;
   logic [15:0] pixel_color;
   logic        status;
   logic        last_of_run;

   modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                   output status, output last_of_run, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input pixel_color,
                 input status, input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: design/bmpd_front.sv
`default_nettype none
module bmpd_front #(
   parameter int MAX_DIM         = 2048,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   bmpd_req_if.sink         req_bus,
   input  logic             q_full,
   output logic             push_valid,
   output bmpd_pkg::cmd_type push_cmd
);
   import bmpd_pkg::*;

   localparam int CW = $clog2(MAX_DIM) + 2;
   localparam int RW = $clog2(MAX_DIM) + 3;

   logic [31:0]   pos_ff, pos_in, offset_ff, offset_in;
   logic [31:0]   width_ff, width_in, height_ff, height_in;
   logic [4:0]    depth_ff, depth_in;
   logic          pfok_ff, pfok_in;
   logic [CW-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [RW-1:0] rbc_ff, rbc_in, row_data_ff, row_data_in, row_size_ff, row_size_in;
   logic [1:0]    phase_ff, phase_in;
   logic [10:0]   pbg_ff, pbg_in;
   logic          err_ff, err_in, done_ff, done_in;
   logic          accept;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && !q_full;

   always_comb begin
      logic [7:0]    b;
      logic [31:0]   p, to_image, rem, wd, rd32;
      logic [10:0]   pal_bytes, rel;
      logic [1:0]    lane;
      logic [3:0]    per;
      logic [RW-1:0] rbc_next;
      logic          ok;
      pos_in      = pos_ff;
      offset_in   = offset_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      depth_in    = depth_ff;
      pfok_in     = pfok_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      rbc_in      = rbc_ff;
      row_data_in = row_data_ff;
      row_size_in = row_size_ff;
      phase_in    = phase_ff;
      pbg_in      = pbg_ff;
      err_in      = err_ff;
      done_in     = done_ff;
      push_valid  = 1'b0;
      push_cmd    = '0;
      b         = req_bus.data_byte;
      p         = '0;
      to_image  = '0;
      rem       = '0;
      wd        = '0;
      rd32      = '0;
      pal_bytes = '0;
      rel       = '0;
      lane      = '0;
      per       = '0;
      rbc_next  = '0;
      ok        = 1'b0;
      if (accept) begin
         if (req_bus.start_of_file) begin
            pos_in    = '0;
            offset_in = '0;
            width_in  = '0;
            height_in = '0;
            depth_in  = '0;
            pfok_in   = 1'b0;
            cur_x_in  = '0;
            cur_y_in  = '0;
            rbc_in    = '0;
            phase_in  = '0;
            pbg_in    = '0;
            err_in    = 1'b0;
            done_in   = 1'b0;
         end
         p = pos_in;
         if (pos_in != '1) begin
            pos_in = pos_in + 32'd1;
         end
         lane = 2'(p[1:0] - 2'd2);
         if (!err_in && !done_in) begin
            if (p <= HEADER_END) begin
               priority if (p >= 32'd10 && p <= 32'd13) begin
                  offset_in[8*lane +: 8] = b;
               end else if (p >= 32'd18 && p <= 32'd21) begin
                  width_in[8*lane +: 8] = b;
               end else if (p >= 32'd22 && p <= 32'd25) begin
                  height_in[8*lane +: 8] = b;
               end else if (p == 32'd26) begin
                  pfok_in = (b == 8'd1);
               end else if (p == 32'd27) begin
                  if (b != 8'd0) pfok_in = 1'b0;
               end else if (p == 32'd28) begin
                  depth_in = (b < 8'd32) ? b[4:0] : 5'd0;
               end else if (p == 32'd29) begin
                  if (b != 8'd0) depth_in = 5'd0;
               end else if (p == 32'd30) begin
                  if (b != 8'd0 && b != 8'd3) pfok_in = 1'b0;
               end else if (p >= 32'd31) begin
                  if (b != 8'd0) pfok_in = 1'b0;
               end else begin
                  pfok_in = pfok_in;
               end
               if (p == HEADER_END) begin
                  ok = pfok_in
                     && (depth_in == 5'd1 || depth_in == 5'd4 || depth_in == 5'd8
                         || depth_in == 5'd24)
                     && width_in != '0 && width_in <= 32'(MAX_DIM)
                     && height_in != '0 && height_in <= 32'(MAX_DIM)
                     && (depth_in == 5'd24 || (32'd1 << depth_in) <= 32'(PALETTE_ENTRIES));
                  unique case (depth_in)
                     5'd1:    wd = width_in;
                     5'd4:    wd = width_in << 2;
                     5'd8:    wd = width_in << 3;
                     default: wd = (width_in << 4) + (width_in << 3);
                  endcase
                  rd32        = (wd + 32'd7) >> 3;
                  row_data_in = RW'(rd32);
                  row_size_in = RW'((rd32 + 32'd3) & ~32'd3);
                  if (ok) begin
                     cur_x_in = '0;
                     cur_y_in = CW'(height_in - 32'd1);
                     rbc_in   = '0;
                     phase_in = '0;
                  end else begin
                     err_in        = 1'b1;
                     push_valid    = 1'b1;
                     push_cmd.kind = CMD_ERROR;
                  end
               end
            end else if (p < offset_in) begin
               if (depth_in != 5'd24) begin
                  to_image  = offset_in - p;
                  pal_bytes = 11'(32'd4 << depth_in);
                  if (to_image <= 32'(pal_bytes)) begin
                     rel = pal_bytes - to_image[10:0];
                     unique case (rel[1:0])
                        2'd0: pbg_in = {6'd0, b[7:3]};
                        2'd1: pbg_in = {b[7:2], pbg_in[4:0]};
                        2'd2: begin
                           if (32'(rel[9:2]) < 32'(PALETTE_ENTRIES)) begin
                              push_valid        = 1'b1;
                              push_cmd.kind     = CMD_PAL_WR;
                              push_cmd.color    = {b[7:3], pbg_in};
                              push_cmd.pal_addr = rel[9:2];
                           end
                        end
                        default: pbg_in = pbg_in;
                     endcase
                  end
               end
            end else begin
               if (rbc_in < row_data_ff) begin
                  if (depth_in == 5'd24) begin
                     unique case (phase_in)
                        2'd0: begin
                           pbg_in   = {6'd0, b[7:3]};
                           phase_in = 2'd1;
                        end
                        2'd1: begin
                           pbg_in   = {b[7:2], pbg_in[4:0]};
                           phase_in = 2'd2;
                        end
                        default: begin
                           if (32'(cur_x_in) < width_in) begin
                              push_valid     = 1'b1;
                              push_cmd.kind  = CMD_PIX_RGB;
                              push_cmd.x     = 11'(cur_x_in);
                              push_cmd.y     = 11'(cur_y_in);
                              push_cmd.color = {b[7:3], pbg_in};
                           end
                           cur_x_in = cur_x_in + CW'(1);
                           phase_in = 2'd0;
                        end
                     endcase
                  end else begin
                     unique case (depth_in)
                        5'd1:    per = 4'd8;
                        5'd4:    per = 4'd2;
                        default: per = 4'd1;
                     endcase
                     rem = width_in - 32'(cur_x_in);
                     if (32'(cur_x_in) < width_in) begin
                        push_valid         = 1'b1;
                        push_cmd.kind      = CMD_PIX_IDX;
                        push_cmd.data_byte = b;
                        push_cmd.depth     = depth_in;
                        push_cmd.x         = 11'(cur_x_in);
                        push_cmd.y         = 11'(cur_y_in);
                        push_cmd.last_step = (rem < 32'(per)) ? 3'(rem - 32'd1)
                                                              : 3'(per - 4'd1);
                     end
                     cur_x_in = cur_x_in + CW'(per);
                  end
               end
               rbc_next = rbc_in + RW'(1);
               if (rbc_next >= row_size_ff) begin
                  rbc_in   = '0;
                  cur_x_in = '0;
                  phase_in = '0;
                  if (cur_y_in == '0) begin
                     done_in = 1'b1;
                  end else begin
                     cur_y_in = cur_y_in - CW'(1);
                  end
               end else begin
                  rbc_in = rbc_next;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         offset_ff <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         depth_ff  <= '0;
         pfok_ff   <= 1'b0;
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         rbc_ff    <= '0;
         phase_ff  <= '0;
         pbg_ff    <= '0;
         err_ff    <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         offset_ff <= offset_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         pfok_ff   <= pfok_in;
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         rbc_ff    <= rbc_in;
         phase_ff  <= phase_in;
         pbg_ff    <= pbg_in;
         err_ff    <= err_in;
         done_ff   <= done_in;
      end
      row_data_ff <= row_data_in;
      row_size_ff <= row_size_in;
   end

endmodule
`default_nettype wire

FILE: design/bmpd_queue.sv
`default_nettype none
module bmpd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bmpd_pkg::cmd_type push_data,
   input  logic              pop,
   output bmpd_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);
   import bmpd_pkg::*;

   cmd_type         store_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (Q_AW + 1)'(Q_DEPTH));
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (Q_AW + 1)'(push) - (Q_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: design/bmpd_back.sv
`default_nettype none
module bmpd_back #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  bmpd_pkg::cmd_type head,
   input  logic              empty,
   output logic              pop,
   bmpd_rsp_if.source        rsp_bus
);
   import bmpd_pkg::*;

   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   logic [15:0] palette_mem [PALETTE_ENTRIES];
   logic [15:0] rd_data_ff;
   logic [2:0]  step_ff, step_in;
   logic        b_valid_ff, b_valid_in;
   logic [10:0] b_x_ff, b_y_ff;
   logic [15:0] b_color_ff;
   logic        b_use_mem_ff, b_status_ff, b_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] rsp_x_ff, rsp_y_ff;
   logic [15:0] rsp_color_ff;
   logic        rsp_status_ff, rsp_last_ff;
   logic        out_free, b_adv, issue, pal_wr, is_idx, idx_last;
   logic [7:0]  idx;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign b_adv    = b_valid_ff && out_free;
   assign pal_wr   = !empty && head.kind == CMD_PAL_WR;
   assign is_idx   = head.kind == CMD_PIX_IDX;
   assign issue    = !empty && head.kind != CMD_PAL_WR && (!b_valid_ff || b_adv);
   assign idx_last = step_ff == head.last_step;
   assign pop      = pal_wr || (issue && (!is_idx || idx_last));

   always_comb begin
      unique case (head.depth)
         5'd1:    idx = {7'd0, head.data_byte[3'd7 - step_ff]};
         5'd4:    idx = step_ff[0] ? {4'd0, head.data_byte[3:0]}
                                   : {4'd0, head.data_byte[7:4]};
         default: idx = head.data_byte;
      endcase
      step_in = step_ff;
      if (issue && is_idx) begin
         step_in = idx_last ? 3'd0 : step_ff + 3'd1;
      end
      b_valid_in = issue ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);
      rsp_valid_in = b_adv ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pal_wr) begin
         palette_mem[head.pal_addr[AW-1:0]] <= head.color;
      end
      if (issue && is_idx) begin
         rd_data_ff <= palette_mem[idx[AW-1:0]];
      end
      if (issue) begin
         b_x_ff       <= head.x + 11'(step_ff);
         b_y_ff       <= head.y;
         b_color_ff   <= head.color;
         b_use_mem_ff <= is_idx;
         b_status_ff  <= head.kind == CMD_ERROR;
         b_last_ff    <= !is_idx || idx_last;
      end
      if (b_adv) begin
         rsp_x_ff      <= b_x_ff;
         rsp_y_ff      <= b_y_ff;
         rsp_color_ff  <= b_use_mem_ff ? rd_data_ff : b_color_ff;
         rsp_status_ff <= b_status_ff;
         rsp_last_ff   <= b_last_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pixel_x     = rsp_x_ff;
   assign rsp_bus.pixel_y     = rsp_y_ff;
   assign rsp_bus.pixel_color = rsp_color_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

endmodule
`default_nettype wire

FILE: design/bmp_stream_pixel_decoder.sv
`default_nettype none
// Streaming bitmap decoder: one file byte is taken per item and each image pixel comes out as an
// RGB565 item with its column and row, bottom row first, or a single error item if the header is
// unsupported. The byte side takes one byte per cycle while the four-entry command queue has room;
// the pixel side gives one item per cycle while the receiver is ready; a 1-bit byte yields up to
// eight items, a 4-bit byte up to two, an 8-bit byte one, set by the single palette read port.
module bmp_stream_pixel_decoder #(
   parameter int MAX_DIM         = 2048,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic       clock,
   input  logic       reset,
   bmpd_req_if.sink   req_bus,
   bmpd_rsp_if.source rsp_bus
);
   import bmpd_pkg::*;

   cmd_type q_push_cmd, q_head;
   logic    q_push, q_pop, q_empty, q_full;

   bmpd_front #(
      .MAX_DIM(MAX_DIM),
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .q_full(q_full),
      .push_valid(q_push),
      .push_cmd(q_push_cmd)
   );

   bmpd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_push_cmd),
      .pop(q_pop),
      .head(q_head),
      .empty(q_empty),
      .full(q_full)
   );

   bmpd_back #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head(q_head),
      .empty(q_empty),
      .pop(q_pop),
      .rsp_bus(rsp_bus)
   );

`ifndef ASSERT_OFF
   a_no_push_full: assert property (@(posedge clock) disable iff (reset) !(q_push && q_full))
      else $error("command pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) !(q_pop && q_empty))
      else $error("command popped from an empty queue");
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status |-> rsp_bus.last_of_run)
      else $error("error item not marked as last");
   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp_bus.valid)
      else $error("result valid straight after reset");
`endif

endmodule
`default_nettype wire
